FILE: rtl/aes_pkg.sv
`default_nettype none
package aes_pkg;

   localparam int NumRounds = 10;
   localparam int CsrIdxW = 3;

   localparam logic [CsrIdxW-1:0] CSR_KEY_HIGH = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_KEY_LOW  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_IV_HIGH  = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_IV_LOW   = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_DECRYPT  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_CHAIN    = 3'd5;

   typedef logic [7:0] sbox_tab_type [256];

   localparam sbox_tab_type SBOX = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic sbox_tab_type build_inv();
      sbox_tab_type r;
      for (int i = 0; i < 256; i++) begin
         r[SBOX[i]] = i[7:0];
      end
      return r;
   endfunction

   localparam sbox_tab_type INV_SBOX = build_inv();

   localparam logic [7:0] RCON [11] = '{
      8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic logic [31:0] sub_word(input logic [31:0] w, input logic inv);
      logic [31:0] r;
      for (int i = 0; i < 4; i++) begin
         r[8*i +: 8] = inv ? INV_SBOX[w[8*i +: 8]] : SBOX[w[8*i +: 8]];
      end
      return r;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   // byte 0 of the column in bits 31:24
   function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
      logic [7:0] m [4];
      logic [7:0] acc;
      logic [31:0] r;
      m[0] = inv ? 8'h0e : 8'h02;
      m[1] = inv ? 8'h0b : 8'h03;
      m[2] = inv ? 8'h0d : 8'h01;
      m[3] = inv ? 8'h09 : 8'h01;
      for (int rr = 0; rr < 4; rr++) begin
         acc = 8'h00;
         for (int k = 0; k < 4; k++) begin
            acc = acc ^ gf_mul(m[(k - rr + 4) & 3], c[31-8*k -: 8]);
         end
         r[31-8*rr -: 8] = acc;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/aes_req_if.sv
`default_nettype none
interface aes_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_high;
   logic [63:0] data_low;
   logic        first_block;
   modport source (output valid, data_high, data_low, first_block, input ready);
   modport sink (input valid, data_high, data_low, first_block, output ready);
endinterface
`default_nettype wire

FILE: rtl/aes_rsp_if.sv
`default_nettype none
interface aes_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;
   modport source (output valid, result_high, result_low, input ready);
   modport sink (input valid, result_high, result_low, output ready);
endinterface
`default_nettype wire

FILE: rtl/aes_csr_if.sv
`default_nettype none
interface aes_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/aes_col_lane.sv
`default_nettype none
module aes_col_lane
   import aes_pkg::*;
(
   input  wire logic [31:0] col,
   input  wire logic [31:0] rkey,
   input  wire logic        decrypt,
   input  wire logic        last,
   output logic [31:0]      col_out
);
   logic [31:0] sub;
   logic [31:0] keyed;

   always_comb begin
      sub = sub_word(col, decrypt);
      if (decrypt) begin
         keyed   = sub ^ rkey;
         col_out = last ? keyed : mix_col(keyed, 1'b1);
      end else begin
         keyed   = last ? sub : mix_col(sub, 1'b0);
         col_out = keyed ^ rkey;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/aes_key_sched.sv
`default_nettype none
module aes_key_sched
   import aes_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         load,
   input  wire logic [127:0] key,
   input  wire logic [3:0]   rd_round,
   output logic [127:0]      rd_key,
   output logic              busy
);
   logic [127:0] rk_ff [NumRounds+1];
   logic [3:0]   cnt_ff, cnt_in;
   logic         on_ff, on_in;
   logic [127:0] prev;
   logic [127:0] next;
   logic [31:0]  t;

   assign rd_key = rk_ff[rd_round];
   assign busy   = on_ff;

   always_comb begin
      prev = rk_ff[cnt_ff - 4'd1];
      t = sub_word({prev[23:0], prev[31:24]}, 1'b0) ^ {RCON[cnt_ff], 24'h0};
      next[127:96] = prev[127:96] ^ t;
      next[95:64]  = prev[95:64] ^ next[127:96];
      next[63:32]  = prev[63:32] ^ next[95:64];
      next[31:0]   = prev[31:0] ^ next[63:32];
      on_in  = on_ff;
      cnt_in = cnt_ff;
      if (load) begin
         on_in  = 1'b1;
         cnt_in = 4'd0;
      end else if (on_ff) begin
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(NumRounds)) on_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (on_ff && !load) begin
         rk_ff[cnt_ff] <= (cnt_ff == 4'd0) ? key : next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff  <= 1'b0;
         cnt_ff <= 4'd0;
      end else begin
         on_ff  <= on_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/aes128_cbc_cipher_unit.sv
// channel  dir  fields
// req_if   in   data_high[64] data_low[64] first_block
// rsp_if   out  result_high[64] result_low[64]
// csr_if   in   index[3] data[64], always ready
// A block is loaded with the first round key added, then makes ten passes of
// the round through four column lanes; a new block is taken only after it finishes.
// A key write expands the round keys again; requests wait until that is done.
// A finished block waits in the output register; the last round stalls
// only while that register is still full. Reset is synchronous.
`default_nettype none
module aes128_cbc_cipher_unit
   import aes_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   aes_req_if.sink    req_if,
   aes_rsp_if.source  rsp_if,
   aes_csr_if.sink    csr_if
);
   logic [63:0]  key_hi_ff, key_lo_ff, iv_hi_ff, iv_lo_ff;
   logic         dec_ff, chain_ff;
   logic [127:0] cv_ff, xor_ff, st_ff, out_ff;
   logic         busy_ff, rsp_valid_ff;
   logic [3:0]   cnt_ff;
   logic         csr_wr, key_load, key_busy, req_acc, last, fin;
   logic [127:0] prev, blk, rkey, shifted, rnd;
   logic [3:0]   rd_round;

   assign csr_if.ready = 1'b1;
   assign csr_wr   = csr_if.valid;
   assign key_load = csr_wr && (csr_if.index == CSR_KEY_HIGH || csr_if.index == CSR_KEY_LOW);
   assign req_if.ready = !busy_ff && !key_busy;
   assign req_acc  = req_if.valid && req_if.ready;
   assign last     = (cnt_ff == 4'(NumRounds));
   assign fin      = busy_ff && last && (!rsp_valid_ff || rsp_if.ready);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.result_high = out_ff[127:64];
   assign rsp_if.result_low  = out_ff[63:0];

   always_comb begin
      if (!busy_ff) rd_round = dec_ff ? 4'(NumRounds) : 4'd0;
      else rd_round = dec_ff ? 4'(NumRounds) - cnt_ff : cnt_ff;
      prev = (chain_ff && req_if.first_block) ? {iv_hi_ff, iv_lo_ff} : cv_ff;
      blk  = {req_if.data_high, req_if.data_low};
      if (chain_ff && !dec_ff) blk = blk ^ prev;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            shifted[127-8*(c*4+r) -: 8] = dec_ff ?
               st_ff[127-8*(((c - r + 4) & 3)*4+r) -: 8] :
               st_ff[127-8*(((c + r) & 3)*4+r) -: 8];
         end
      end
   end

   aes_key_sched u_key (
      .clock(clock), .reset(reset), .load(key_load),
      .key({key_hi_ff, key_lo_ff}), .rd_round(rd_round), .rd_key(rkey), .busy(key_busy)
   );

   for (genvar g = 0; g < 4; g++) begin : g_lane
      aes_col_lane u_lane (
         .col(shifted[127-32*g -: 32]), .rkey(rkey[127-32*g -: 32]),
         .decrypt(dec_ff), .last(last), .col_out(rnd[127-32*g -: 32])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0; key_lo_ff <= '0; iv_hi_ff <= '0; iv_lo_ff <= '0;
         dec_ff <= 1'b0; chain_ff <= 1'b1; cv_ff <= '0;
         busy_ff <= 1'b0; rsp_valid_ff <= 1'b0; cnt_ff <= 4'd0;
      end else begin
         if (csr_wr) begin
            case (csr_if.index)
               CSR_KEY_HIGH: key_hi_ff <= csr_if.data;
               CSR_KEY_LOW:  key_lo_ff <= csr_if.data;
               CSR_IV_HIGH:  iv_hi_ff  <= csr_if.data;
               CSR_IV_LOW:   iv_lo_ff  <= csr_if.data;
               CSR_DECRYPT:  dec_ff    <= csr_if.data[0];
               CSR_CHAIN:    chain_ff  <= csr_if.data[0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_if.ready) rsp_valid_ff <= 1'b0;
         if (req_acc) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 4'd1;
            if (dec_ff) cv_ff <= {req_if.data_high, req_if.data_low};
         end else if (fin) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            if (!dec_ff) cv_ff <= rnd;
         end else if (busy_ff && !last) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         st_ff  <= blk ^ rkey;
         xor_ff <= (chain_ff && dec_ff) ? prev : '0;
      end else if (busy_ff && !last) begin
         st_ff <= rnd;
      end
      if (fin) out_ff <= rnd ^ xor_ff;
   end

   a_acc_busy: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> busy_ff) else $error("no run after accept");
   a_key_block: assert property (@(posedge clock) disable iff (reset)
      key_busy |-> !req_if.ready) else $error("request taken during key expansion");
   a_fin_valid: assert property (@(posedge clock) disable iff (reset)
      fin |=> rsp_valid_ff && !busy_ff) else $error("result not posted");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != 4'd0 && cnt_ff <= 4'(NumRounds))) else $error("round count");
endmodule
`default_nettype wire

FILE: tb/tb_aes128_cbc_cipher_unit.sv
`timescale 1ns / 1ps
module tb_aes128_cbc_cipher_unit;
   import aes_pkg::*;

   typedef struct packed {
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic        first_block;
   } block_req_t;

   typedef struct packed {
      logic [63:0] result_high;
      logic [63:0] result_low;
   } block_rsp_t;

   localparam int WatchdogLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   aes_req_if req_if();
   aes_rsp_if rsp_if();
   aes_csr_if csr_if();

   aes128_cbc_cipher_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if.sink),
      .rsp_if (rsp_if.source),
      .csr_if (csr_if.sink)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // cipher model state
   logic [63:0] m_key_high, m_key_low, m_iv_high, m_iv_low;
   logic        m_decrypt, m_chain;
   logic [63:0] m_cv_high, m_cv_low;
   logic [7:0]  rk [11][16];
   logic [7:0]  inv_box [256];

   block_req_t pending_blocks [$];
   block_rsp_t expected_blocks [$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  quiet_cycles = 0;

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   task automatic expand_round_keys();
      logic [7:0] w [176];
      logic [7:0] t [4];
      for (int i = 0; i < 8; i++) begin
         w[i] = m_key_high[63-8*i -: 8];
         w[8+i] = m_key_low[63-8*i -: 8];
      end
      for (int i = 4; i < 44; i++) begin
         int p;
         p = 4 * (i - 1);
         if ((i & 3) == 0) begin
            t[0] = SBOX[w[p+1]] ^ RCON[i/4];
            t[1] = SBOX[w[p+2]];
            t[2] = SBOX[w[p+3]];
            t[3] = SBOX[w[p]];
         end else begin
            for (int k = 0; k < 4; k++) t[k] = w[p+k];
         end
         for (int k = 0; k < 4; k++) w[4*i+k] = t[k] ^ w[4*(i-4)+k];
      end
      for (int r = 0; r < 11; r++)
         for (int k = 0; k < 16; k++) rk[r][k] = w[16*r+k];
   endtask

   function automatic logic [127:0] cipher_block(input logic [127:0] blk, input logic inv);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] mf [4];
      logic [127:0] o;
      int rnd;
      if (inv) mf = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      else mf = '{8'h02, 8'h03, 8'h01, 8'h01};
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (int step = 0; step < 11; step++) begin
         rnd = inv ? 10 - step : step;
         if (step > 0) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  t[c*4+r] = s[(inv ? (c - r + 4) : (c + r)) % 4 * 4 + r];
            for (int i = 0; i < 16; i++) s[i] = inv ? inv_box[t[i]] : SBOX[t[i]];
            if (!inv && step < 10) begin
               for (int c = 0; c < 4; c++)
                  for (int r = 0; r < 4; r++) begin
                     t[c*4+r] = 8'h00;
                     for (int k = 0; k < 4; k++)
                        t[c*4+r] ^= gmul(mf[(k - r + 4) & 3], s[c*4+k]);
                  end
               s = t;
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= rk[rnd][i];
         if (inv && step > 0 && step < 10) begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) begin
                  t[c*4+r] = 8'h00;
                  for (int k = 0; k < 4; k++)
                     t[c*4+r] ^= gmul(mf[(k - r + 4) & 3], s[c*4+k]);
               end
            s = t;
         end
      end
      for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
      return o;
   endfunction

   task automatic predict_block(input block_req_t b);
      logic [127:0] prev, res;
      block_rsp_t e;
      prev = (m_chain && b.first_block) ? {m_iv_high, m_iv_low} : {m_cv_high, m_cv_low};
      if (m_decrypt) begin
         res = cipher_block({b.data_high, b.data_low}, 1'b1);
         if (m_chain) res ^= prev;
         {m_cv_high, m_cv_low} = {b.data_high, b.data_low};
      end else begin
         res = cipher_block({b.data_high, b.data_low} ^ (m_chain ? prev : 128'h0), 1'b0);
         {m_cv_high, m_cv_low} = res;
      end
      e.result_high = res[127:64];
      e.result_low = res[63:0];
      expected_blocks.push_back(e);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) predict_block(
            '{req_if.data_high, req_if.data_low, req_if.first_block});
         if (!req_if.valid || req_if.ready) begin
            if (pending_blocks.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               block_req_t b;
               b = pending_blocks.pop_front();
               req_if.valid <= 1'b1;
               req_if.data_high <= b.data_high;
               req_if.data_low <= b.data_low;
               req_if.first_block <= b.first_block;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_blocks.size() == 0) begin
               $display("%0t: unexpected result %h %h", $time,
                        rsp_if.result_high, rsp_if.result_low);
               errors++;
            end else begin
               block_rsp_t e;
               e = expected_blocks.pop_front();
               if (e.result_high !== rsp_if.result_high) begin
                  $display("%0t: result_high expected %h actual %h", $time,
                           e.result_high, rsp_if.result_high);
                  errors++;
               end
               if (e.result_low !== rsp_if.result_low) begin
                  $display("%0t: result_low expected %h actual %h", $time,
                           e.result_low, rsp_if.result_low);
                  errors++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
         if ((rsp_if.valid && rsp_if.ready) || (req_if.valid && req_if.ready)
             || (csr_if.valid && csr_if.ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("tb_aes128_cbc_cipher_unit: done, errors");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [63:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= val;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      case (idx)
         CSR_KEY_HIGH: begin m_key_high = val; expand_round_keys(); end
         CSR_KEY_LOW:  begin m_key_low = val; expand_round_keys(); end
         CSR_IV_HIGH:  m_iv_high = val;
         CSR_IV_LOW:   m_iv_low = val;
         CSR_DECRYPT:  m_decrypt = val[0];
         CSR_CHAIN:    m_chain = val[0];
         default: ;
      endcase
   endtask

   // sample at the falling edge so driver and monitor updates have settled
   task automatic drain();
      while (pending_blocks.size() > 0 || req_if.valid || expected_blocks.size() > 0)
         @(negedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic queue_block(input logic [63:0] h, input logic [63:0] l, input logic f);
      pending_blocks.push_back('{h, l, f});
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(input int n, input int sidle, input int rstall);
      send_idle_pct = sidle;
      recv_stall_pct = rstall;
      csr_write(CSR_KEY_HIGH, rand64());
      csr_write(CSR_KEY_LOW, rand64());
      csr_write(CSR_IV_HIGH, rand64());
      csr_write(CSR_IV_LOW, rand64());
      csr_write(CSR_DECRYPT, rand64());
      csr_write(CSR_CHAIN, ($urandom_range(3) != 0) ? 64'h1 : rand64());
      for (int i = 0; i < n; i++)
         queue_block(rand64(), rand64(), ($urandom_range(5) == 0));
      drain();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.data_high = '0;
      req_if.data_low = '0;
      req_if.first_block = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      for (int i = 0; i < 256; i++) inv_box[SBOX[i]] = i[7:0];
      m_key_high = '0; m_key_low = '0; m_iv_high = '0; m_iv_low = '0;
      m_decrypt = 1'b0; m_chain = 1'b1; m_cv_high = '0; m_cv_low = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // FIPS-197 vector, chaining off, then on without first block
      csr_write(CSR_KEY_HIGH, 64'h0001020304050607);
      csr_write(CSR_KEY_LOW, 64'h08090a0b0c0d0e0f);
      csr_write(CSR_CHAIN, 64'h0);
      queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
      queue_block(64'h0, 64'h0, 1'b0);
      queue_block('1, '1, 1'b0);
      drain();
      csr_write(CSR_CHAIN, 64'hffff_ffff_ffff_fffe);
      csr_write(CSR_CHAIN, 64'hffff_ffff_ffff_ffff);
      csr_write(3'd6, rand64());
      csr_write(3'd7, rand64());
      queue_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain();
      csr_write(CSR_IV_HIGH, '1);
      csr_write(CSR_IV_LOW, 64'h0);
      queue_block('1, 64'h0, 1'b1);
      queue_block(64'h0, '1, 1'b0);
      queue_block(64'h8000000000000000, 64'h1, 1'b0);
      drain();
      csr_write(CSR_DECRYPT, 64'h1);
      queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
      queue_block('1, '1, 1'b0);
      queue_block(64'h0, 64'h0, 1'b1);
      drain();
      csr_write(CSR_CHAIN, 64'h0);
      queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
      drain();
      csr_write(CSR_KEY_HIGH, '1);
      csr_write(CSR_KEY_LOW, '1);
      csr_write(CSR_DECRYPT, 64'h2);
      queue_block('1, '1, 1'b1);
      drain();

      random_phase(60, 0, 0);
      random_phase(60, 0, 0);
      random_phase(60, 57, 0);
      random_phase(60, 0, 57);
      random_phase(60, 32, 32);
      random_phase(50, 57, 57);
      random_phase(50, 32, 32);
      random_phase(50, 0, 0);

      if (errors == 0) begin
         $display("tb_aes128_cbc_cipher_unit: done, clean");
      end else begin
         $display("tb_aes128_cbc_cipher_unit: done, errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/aes_pkg.sv
rtl/aes_req_if.sv
rtl/aes_rsp_if.sv
rtl/aes_csr_if.sv
rtl/aes_col_lane.sv
rtl/aes_key_sched.sv
rtl/aes128_cbc_cipher_unit.sv
tb/tb_aes128_cbc_cipher_unit.sv
